>>> hw/rtl/median_filter_3x3_core_defines.svh
// assertion helpers for the median filter block
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, quiet in reset
`define MF3_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, quiet in reset
`define MF3_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

    localparam int MAX_ROW_BYTES_DEF = 4096;
    localparam int ROW_COUNT_MAX     = 4096;
    localparam int CFG_W             = 13;
    localparam int PIX_W             = 8;
    localparam int WIN               = 3;

    // output queue, sized to cover every stage between accept and queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    localparam logic REQ_PAD = 1'b1;

    typedef enum logic {
        REG_ROW_BYTES = 1'b0,
        REG_ROW_COUNT = 1'b1
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN*WIN-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic vld;
        logic use_med;
        logic sel_edge;
        logic last;
    } t_flags;

    typedef struct packed {
        t_flags flags;
        t_pix   edge_byte;
    } t_med_ctl;

    typedef struct packed {
        logic s3_vld;
        logic s4_vld;
    } t_med_sts;

    typedef struct packed {
        t_pix filtered_byte;
        logic frame_last;
    } t_res;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_sts;

endpackage

`default_nettype wire

>>> hw/rtl/mf3_in_if.sv
`default_nettype none

interface mf3_in_if;
    logic          valid;
    logic          ready;
    logic          req_type;
    mf3_pkg::t_pix pixel_byte;

    modport source (output valid, output req_type, output pixel_byte, input ready);
    modport sink   (input valid, input req_type, input pixel_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mf3_out_if.sv
`default_nettype none

interface mf3_out_if;
    logic          valid;
    logic          ready;
    mf3_pkg::t_pix filtered_byte;
    logic          frame_last;

    modport source (output valid, output filtered_byte, output frame_last, input ready);
    modport sink   (input valid, input filtered_byte, input frame_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mf3_ram.sv
`default_nettype none

// one write port, two registered read ports, read-before-write
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

>>> hw/rtl/mf3_median.sv
`default_nettype none

// two-stage median of nine: sort columns, then lo/mid/hi reduction
module mf3_median (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mf3_pkg::t_win     i_win,
    input  wire mf3_pkg::t_med_ctl i_ctl,
    output mf3_pkg::t_med_sts      o_sts,
    output logic                   o_res_vld,
    output mf3_pkg::t_res          o_res
);

    function automatic mf3_pkg::t_pix f_min(input mf3_pkg::t_pix a, input mf3_pkg::t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::t_pix f_max(input mf3_pkg::t_pix a, input mf3_pkg::t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::t_pix f_med3(input mf3_pkg::t_pix a, input mf3_pkg::t_pix b,
                                             input mf3_pkg::t_pix c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    mf3_pkg::t_pix col_lo [mf3_pkg::WIN];
    mf3_pkg::t_pix col_md [mf3_pkg::WIN];
    mf3_pkg::t_pix col_hi [mf3_pkg::WIN];

    mf3_pkg::t_pix   r_s3_lo [mf3_pkg::WIN];
    mf3_pkg::t_pix   r_s3_md [mf3_pkg::WIN];
    mf3_pkg::t_pix   r_s3_hi [mf3_pkg::WIN];
    mf3_pkg::t_flags r_s3_flags;
    mf3_pkg::t_pix   r_s3_pass;

    mf3_pkg::t_pix   r_s4_lo;
    mf3_pkg::t_pix   r_s4_md;
    mf3_pkg::t_pix   r_s4_hi;
    mf3_pkg::t_flags r_s4_flags;
    mf3_pkg::t_pix   r_s4_pass;

    // per column three-element sorting network
    always_comb begin
        mf3_pkg::t_pix lo1;
        mf3_pkg::t_pix hi1;
        mf3_pkg::t_pix tmp;
        for (int c = 0; c < mf3_pkg::WIN; c++) begin
            lo1 = f_min(i_win[c], i_win[mf3_pkg::WIN + c]);
            hi1 = f_max(i_win[c], i_win[mf3_pkg::WIN + c]);
            tmp = f_max(lo1, i_win[2*mf3_pkg::WIN + c]);
            col_lo[c] = f_min(lo1, i_win[2*mf3_pkg::WIN + c]);
            col_md[c] = f_min(hi1, tmp);
            col_hi[c] = f_max(hi1, tmp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_flags <= '0;
            r_s4_flags <= '0;
        end else begin
            r_s3_flags <= i_ctl.flags;
            r_s4_flags <= r_s3_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_lo   <= col_lo;
        r_s3_md   <= col_md;
        r_s3_hi   <= col_hi;
        r_s3_pass <= i_ctl.flags.sel_edge ? i_ctl.edge_byte : i_win[mf3_pkg::WIN + 1];
        r_s4_lo   <= f_max(f_max(r_s3_lo[0], r_s3_lo[1]), r_s3_lo[2]);
        r_s4_md   <= f_med3(r_s3_md[0], r_s3_md[1], r_s3_md[2]);
        r_s4_hi   <= f_min(f_min(r_s3_hi[0], r_s3_hi[1]), r_s3_hi[2]);
        r_s4_pass <= r_s3_pass;
    end

    assign o_sts.s3_vld       = r_s3_flags.vld;
    assign o_sts.s4_vld       = r_s4_flags.vld;
    assign o_res_vld          = r_s4_flags.vld;
    assign o_res.filtered_byte = r_s4_flags.use_med ? f_med3(r_s4_lo, r_s4_md, r_s4_hi)
                                                    : r_s4_pass;
    assign o_res.frame_last   = r_s4_flags.last;

endmodule

`default_nettype wire

>>> hw/rtl/mf3_fifo.sv
`default_nettype none

// result queue; the producer holds back by credit, so push never meets a full queue
module mf3_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mf3_pkg::t_res i_data,
    output mf3_pkg::t_fifo_sts o_sts,
    mf3_out_if.source          o_out
);

    mf3_pkg::t_res                   r_mem [mf3_pkg::FIFO_DEPTH];
    logic [mf3_pkg::FIFO_PTR_W-1:0]  r_wptr;
    logic [mf3_pkg::FIFO_PTR_W-1:0]  r_rptr;
    logic [mf3_pkg::FIFO_CNT_W-1:0]  r_count;
    logic [mf3_pkg::FIFO_PTR_W-1:0]  n_wptr;
    logic [mf3_pkg::FIFO_PTR_W-1:0]  n_rptr;
    logic [mf3_pkg::FIFO_CNT_W-1:0]  n_count;
    logic                            pop;

    localparam logic [mf3_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        mf3_pkg::FIFO_PTR_W'(mf3_pkg::FIFO_DEPTH - 1);

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_sts.count         = r_count;
    assign o_out.valid         = (r_count != '0);
    assign o_out.filtered_byte = r_mem[r_rptr].filtered_byte;
    assign o_out.frame_last    = r_mem[r_rptr].frame_last;

endmodule

`default_nettype wire

>>> hw/rtl/median_filter_3x3_core.sv
// channel   dir  handshake     payload
// i_in      in   valid/ready   req_type, pixel_byte
// o_out     out  valid/ready   filtered_byte, frame_last
// apb       in   psel/penable  paddr, pwdata -> prdata (pready tied high)
//
// one item per clock while input ready is high; a result passes stage 1, the window,
// the median stages and the queue to o_out; one line store read/modify/write a cycle
// line stores need no clearing pass, so the block takes input straight out of reset
// synchronous active-low reset clears position, window, pipeline and queue state
// output stalls back up through an 8-entry result queue; input ready drops when
// queued plus in-flight results fill it
`default_nettype none
`include "median_filter_3x3_core_defines.svh"

module median_filter_3x3_core #(
    parameter int MAX_ROW_BYTES = mf3_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mf3_in_if.sink           i_in,
    mf3_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW   = $clog2(MAX_ROW_BYTES);      // column index, line store address
    localparam int WW   = $clog2(MAX_ROW_BYTES + 1);  // holds row width itself
    localparam int KW   = (WW > mf3_pkg::CFG_W) ? WW : mf3_pkg::CFG_W;
    localparam int RW   = mf3_pkg::CFG_W;
    localparam int PW   = mf3_pkg::PIX_W;
    localparam int CNTW = mf3_pkg::FIFO_CNT_W + 1;

    // configuration registers
    logic [mf3_pkg::CFG_W-1:0] r_row_bytes;
    logic [mf3_pkg::CFG_W-1:0] r_row_count;
    logic                      cfg_we;

    // clamped frame sizes
    logic [KW-1:0] rb_ext;
    logic [KW-1:0] w_k;
    logic [WW-1:0] w_cols;
    logic [RW-1:0] h_rows;
    logic [RW-1:0] h_p1;

    // frame position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [WW-1:0] col_inc;
    logic          frame_end;
    logic          acc;
    mf3_pkg::t_flags flags;
    mf3_pkg::t_pix   x_in;

    // stage 1: line store data back, read/modify/write
    logic            r_s1_busy;
    mf3_pkg::t_flags r_s1_flags;
    logic [CW-1:0]   r_s1_ci;
    mf3_pkg::t_pix   r_s1_x;
    logic            r_hit_a;
    logic            r_hit_e;
    logic [2*PW-1:0] r_fwd;
    logic [2*PW-1:0] rd_a;
    logic [2*PW-1:0] rd_b;
    logic [2*PW-1:0] wr_data;
    logic [CW-1:0]   edge_addr;
    mf3_pkg::t_pix   s1_top;
    mf3_pkg::t_pix   s1_mid;
    mf3_pkg::t_pix   s1_edge;

    // stage 2: window
    mf3_pkg::t_win    r_win;
    mf3_pkg::t_med_ctl r_s2_ctl;

    // median pipe and queue
    mf3_pkg::t_med_sts  med_sts;
    logic               med_res_vld;
    mf3_pkg::t_res      med_res;
    mf3_pkg::t_fifo_sts fifo_sts;
    logic [CNTW-1:0]    credit_use;

    // ---------------------------------------------------------------------
    // configuration port: decoded on paddr[2], zero wait states
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= mf3_pkg::CFG_W'(3);
            r_row_count <= mf3_pkg::CFG_W'(3);
        end else if (cfg_we) begin
            unique case (mf3_pkg::t_reg_idx'(paddr[2]))
                mf3_pkg::REG_ROW_BYTES: r_row_bytes <= pwdata[mf3_pkg::CFG_W-1:0];
                mf3_pkg::REG_ROW_COUNT: r_row_count <= pwdata[mf3_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (mf3_pkg::t_reg_idx'(paddr[2]))
            mf3_pkg::REG_ROW_BYTES: prdata = 32'(r_row_bytes);
            mf3_pkg::REG_ROW_COUNT: prdata = 32'(r_row_count);
        endcase
    end

    // ---------------------------------------------------------------------
    // clamp sizes: row width to [3, MAX_ROW_BYTES], rows to [3, 4096]
    // ---------------------------------------------------------------------
    assign rb_ext = KW'(r_row_bytes);

    always_comb begin
        if (rb_ext < KW'(3)) begin
            w_k = KW'(3);
        end else if (rb_ext > KW'(MAX_ROW_BYTES)) begin
            w_k = KW'(MAX_ROW_BYTES);
        end else begin
            w_k = rb_ext;
        end
        if (r_row_count < RW'(3)) begin
            h_rows = RW'(3);
        end else if (r_row_count > RW'(mf3_pkg::ROW_COUNT_MAX)) begin
            h_rows = RW'(mf3_pkg::ROW_COUNT_MAX);
        end else begin
            h_rows = r_row_count;
        end
    end

    assign w_cols    = w_k[WW-1:0];
    assign h_p1      = h_rows + RW'(1);
    assign edge_addr = CW'(w_cols - WW'(1));

    // ---------------------------------------------------------------------
    // position of the arriving item, checked against current sizes
    // ---------------------------------------------------------------------
    always_comb begin
        cur_col = r_col;
        cur_row = r_row;
        // column past the row end wraps to the next row
        if (WW'(r_col) >= w_cols) begin
            cur_col = '0;
            cur_row = r_row + RW'(1);
        end
        // past the drain: restart the frame
        if ((cur_row > h_p1) || ((cur_row == h_p1) && (cur_col != '0))) begin
            cur_col = '0;
            cur_row = '0;
        end

        // the item that drains the last byte closes the frame
        frame_end = (cur_row == h_p1) && (cur_col == '0);
        col_inc   = WW'(cur_col) + WW'(1);

        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_cols) begin
            n_col = '0;
            n_row = cur_row + RW'(1);
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = cur_row;
        end

        // column 0 yields the last byte of the row two above: always border
        if (cur_col == '0) begin
            flags.vld      = (cur_row >= RW'(2)) && (cur_row <= h_p1);
            flags.use_med  = 1'b0;
            flags.sel_edge = 1'b1;
            flags.last     = frame_end;
        end else begin
            flags.vld      = (cur_row >= RW'(1)) && (cur_row <= h_rows);
            flags.use_med  = (cur_row >= RW'(2)) && (cur_row <= h_rows - RW'(1)) &&
                             (WW'(cur_col) >= WW'(2));
            flags.sel_edge = 1'b0;
            flags.last     = 1'b0;
        end
    end

    // padding carries a zero byte into the stores
    assign x_in = (i_in.req_type == mf3_pkg::REQ_PAD) ? '0 : i_in.pixel_byte;

    // credit: queued results plus every result still in the pipe
    assign credit_use = CNTW'(fifo_sts.count) + CNTW'(r_s1_flags.vld) +
                        CNTW'(r_s2_ctl.flags.vld) + CNTW'(med_sts.s3_vld) +
                        CNTW'(med_sts.s4_vld);
    assign i_in.ready = (credit_use < CNTW'(mf3_pkg::FIFO_DEPTH));
    assign acc        = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------------
    // line stores: one memory, upper byte row-before-last, lower byte last row
    // port a reads the item's column, port b the last column for border output
    // ---------------------------------------------------------------------
    mf3_ram #(
        .WIDTH (2*PW),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (r_s1_busy),
        .i_waddr   (r_s1_ci),
        .i_wdata   (wr_data),
        .i_raddr_a (cur_col),
        .i_raddr_b (edge_addr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // forwarding: a write landing on the same edge as the read is not seen by
    // the memory, so the word being written is kept and selected instead
    assign s1_mid  = r_hit_a ? r_fwd[PW-1:0]    : rd_a[PW-1:0];
    assign s1_top  = r_hit_a ? r_fwd[2*PW-1:PW] : rd_a[2*PW-1:PW];
    assign s1_edge = r_hit_e ? r_fwd[2*PW-1:PW] : rd_b[2*PW-1:PW];
    assign wr_data = {s1_mid, r_s1_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_busy  <= 1'b0;
            r_s1_flags <= '0;
            r_hit_a    <= 1'b0;
            r_hit_e    <= 1'b0;
        end else begin
            r_s1_busy  <= acc;
            r_s1_flags <= acc ? flags : '0;
            if (acc) begin
                r_hit_a <= r_s1_busy && (cur_col == r_s1_ci);
                r_hit_e <= r_s1_busy && (edge_addr == r_s1_ci);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ci <= cur_col;
            r_s1_x  <= x_in;
            r_fwd   <= wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // 3x3 window, row-major, column 2 newest
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl.flags     <= r_s1_flags;
            r_s2_ctl.edge_byte <= s1_edge;
            if (r_s1_busy) begin
                for (int r = 0; r < mf3_pkg::WIN; r++) begin
                    r_win[r*mf3_pkg::WIN + 0] <= r_win[r*mf3_pkg::WIN + 1];
                    r_win[r*mf3_pkg::WIN + 1] <= r_win[r*mf3_pkg::WIN + 2];
                end
                r_win[0*mf3_pkg::WIN + 2] <= s1_top;
                r_win[1*mf3_pkg::WIN + 2] <= s1_mid;
                r_win[2*mf3_pkg::WIN + 2] <= r_s1_x;
            end
        end
    end

    mf3_median u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (r_win),
        .i_ctl     (r_s2_ctl),
        .o_sts     (med_sts),
        .o_res_vld (med_res_vld),
        .o_res     (med_res)
    );

    mf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_res_vld),
        .i_data  (med_res),
        .o_sts   (fifo_sts),
        .o_out   (o_out)
    );

    // credit scheme keeps the queue from overflowing
    `MF3_ASSERT_IMP(a_queue_room, med_res_vld, fifo_sts.count != mf3_pkg::FIFO_FULL, "result queue overflow")
    // the draining transaction returns the position to the frame start
    `MF3_ASSERT_NXT(a_frame_restart, acc && frame_end, (r_col == '0) && (r_row == '0), "frame end did not restart position")
    // a last-column write can only be caught by a first-column read
    `MF3_ASSERT_IMP(a_edge_fwd, r_s1_busy && r_hit_e, r_s1_ci == '0, "edge forward outside first column")

endmodule

`default_nettype wire

>>> tb/median_filter_3x3_core_tb.sv
module median_filter_3x3_core_tb;

    // request code for an image byte, the counterpart of the package pad code
    localparam logic REQ_PIXEL = ~mf3_pkg::REQ_PAD;

    localparam int unsigned SIZE_MIN      = 3;
    localparam int unsigned IDLE_MAX      = 15;
    localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 12;    // lets results still in the pipeline come out
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int unsigned ITEM_TARGET   = 1650;

    typedef struct packed {
        logic          req_type;
        mf3_pkg::t_pix pixel_byte;
    } t_px_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mf3_in_if  in_if ();
    mf3_out_if out_if ();

    median_filter_3x3_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: our own copy of the line stores, window, position
    // and register values, advanced once per accepted input transaction
    // ------------------------------------------------------------------
    logic [mf3_pkg::CFG_W-1:0] cfg_row_bytes = mf3_pkg::CFG_W'(SIZE_MIN);
    logic [mf3_pkg::CFG_W-1:0] cfg_row_count = mf3_pkg::CFG_W'(SIZE_MIN);
    mf3_pkg::t_pix store_a [mf3_pkg::MAX_ROW_BYTES_DEF] = '{default: '0};  // previous row
    mf3_pkg::t_pix store_b [mf3_pkg::MAX_ROW_BYTES_DEF] = '{default: '0};  // row before that
    mf3_pkg::t_pix nbr_win [mf3_pkg::WIN*mf3_pkg::WIN] = '{default: '0};   // row-major
    int unsigned   pos_col = 0;
    int unsigned   pos_row = 0;

    mf3_pkg::t_res filtered_expected [$];
    t_px_req       pending_px [$];

    int unsigned errors = 0;
    int unsigned items_taken = 0;
    int unsigned bytes_checked = 0;
    int unsigned queued_items = 0;
    int unsigned settings_run = 0;
    int unsigned hold_req = 0;
    int unsigned holds_done = 0;
    bit          no_gaps = 1'b0;

    function automatic int unsigned clamp_size(input logic [mf3_pkg::CFG_W-1:0] raw,
                                               input int unsigned hi);
        if (raw < SIZE_MIN) return SIZE_MIN;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // middle value of the nine window bytes, by insertion sort of a copy
    function automatic mf3_pkg::t_pix median_of_window();
        mf3_pkg::t_pix s [mf3_pkg::WIN*mf3_pkg::WIN];
        mf3_pkg::t_pix v;
        int            i, j;
        s = nbr_win;
        for (i = 1; i < mf3_pkg::WIN*mf3_pkg::WIN; i++) begin
            v = s[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
        end
        return s[(mf3_pkg::WIN*mf3_pkg::WIN-1)/2];
    endfunction

    // one input transaction: shift the window, update the line stores and
    // queue the filtered byte that this transaction releases, if any
    function automatic void predict_filtered(input logic req, input mf3_pkg::t_pix pix);
        int unsigned   w, h, ci, ri, r;
        mf3_pkg::t_pix x, top, mid, border;
        mf3_pkg::t_res res;
        bit            emit;
        w    = clamp_size(cfg_row_bytes, mf3_pkg::MAX_ROW_BYTES_DEF);
        h    = clamp_size(cfg_row_count, mf3_pkg::ROW_COUNT_MAX);
        emit = 1'b0;
        res  = '0;
        // sizes may have shrunk since the last transaction: wrap or restart
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row > h + 1 || (pos_row == h + 1 && pos_col > 0)) begin
            pos_col = 0;
            pos_row = 0;
        end
        ci = pos_col;
        ri = pos_row;
        // padding inside the image reads as a zero byte
        x      = (req == mf3_pkg::REQ_PAD) ? '0 : pix;
        top    = store_b[ci];
        mid    = store_a[ci];
        border = store_b[w-1];
        for (r = 0; r < mf3_pkg::WIN; r++) begin
            nbr_win[r*mf3_pkg::WIN]   = nbr_win[r*mf3_pkg::WIN+1];
            nbr_win[r*mf3_pkg::WIN+1] = nbr_win[r*mf3_pkg::WIN+2];
        end
        nbr_win[2]                 = top;
        nbr_win[mf3_pkg::WIN+2]    = mid;
        nbr_win[2*mf3_pkg::WIN+2]  = x;
        store_b[ci] = mid;
        store_a[ci] = x;
        if (ci == 0) begin
            // last byte column of two rows back: always a border byte
            if (ri >= 2 && ri <= h + 1) begin
                emit              = 1'b1;
                res.filtered_byte = border;
                res.frame_last    = (ri == h + 1);
            end
        end else if (ri >= 1 && ri <= h) begin
            emit = 1'b1;
            if (ri - 1 >= 1 && ri - 1 <= h - 2 && ci - 1 >= 1 && ci - 1 <= w - 2)
                res.filtered_byte = median_of_window();
            else
                res.filtered_byte = nbr_win[mf3_pkg::WIN+1];
        end
        if (ri == h + 1 && ci == 0) begin
            // frame done, the next transaction starts a fresh frame
            pos_col = 0;
            pos_row = 0;
        end else begin
            pos_col = ci + 1;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row = ri + 1;
            end
        end
        if (emit) filtered_expected.push_back(res);
    endfunction

    // oldest expectation against the result just taken, field by field
    function automatic void check_filtered(input mf3_pkg::t_pix got_byte, input logic got_last);
        mf3_pkg::t_res want;
        if (filtered_expected.size() == 0) begin
            $display("%0t: unexpected result filtered_byte=%0d frame_last=%0b",
                     $time, got_byte, got_last);
            errors++;
            return;
        end
        want = filtered_expected.pop_front();
        bytes_checked++;
        if (got_byte !== want.filtered_byte) begin
            $display("%0t: filtered_byte expected %0d actual %0d",
                     $time, want.filtered_byte, got_byte);
            errors++;
        end
        if (got_last !== want.frame_last) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.frame_last, got_last);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // pixel driver: takes items from the pending queue, waits a drawn
    // number of idle cycles before each one, and feeds the predictor on
    // every accepted transaction
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;

    always @(posedge i_clk) begin : drive_pixels
        t_px_req     nxt;
        int unsigned gap;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_wait   <= 0;
        end else if (in_if.valid && in_if.ready) begin
            predict_filtered(in_if.req_type, in_if.pixel_byte);
            items_taken++;
            gap = no_gaps ? 0 : $urandom_range(0, IDLE_MAX);
            if (gap == 0 && pending_px.size() != 0) begin
                // back-to-back: valid stays high, only the payload moves on
                nxt = pending_px.pop_front();
                in_if.req_type   <= nxt.req_type;
                in_if.pixel_byte <= nxt.pixel_byte;
            end else begin
                in_if.valid <= 1'b0;
                send_wait   <= (gap == 0) ? 0 : gap - 1;
            end
        end else if (!in_if.valid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_px.size() != 0) begin
                nxt = pending_px.pop_front();
                in_if.valid      <= 1'b1;
                in_if.req_type   <= nxt.req_type;
                in_if.pixel_byte <= nxt.pixel_byte;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each output transaction, then drops ready for
    // a drawn number of cycles; a hold request makes it stall for a long
    // stretch so that the block backs up and stalls its input
    // ------------------------------------------------------------------
    int unsigned take_wait = 0;
    int unsigned hold_seen = 0;

    always @(posedge i_clk) begin : sink_results
        int unsigned gap;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_wait    <= 0;
            hold_seen    <= hold_req;
        end else begin
            if (out_if.valid && out_if.ready)
                check_filtered(out_if.filtered_byte, out_if.frame_last);
            if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                out_if.ready <= 1'b0;
                take_wait    <= HOLD_CYCLES;
                holds_done++;
            end else if (out_if.valid && out_if.ready) begin
                gap = no_gaps ? 0 : $urandom_range(0, IDLE_MAX);
                if (gap != 0) begin
                    out_if.ready <= 1'b0;
                    take_wait    <= gap - 1;
                end
            end else if (!out_if.ready) begin
                if (take_wait != 0)
                    take_wait <= take_wait - 1;
                else
                    out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_px(input logic req, input mf3_pkg::t_pix val);
        pending_px.push_back('{req_type: req, pixel_byte: val});
        queued_items++;
    endtask

    // occasional flip of the request type: padding inside the image or an
    // image byte inside the drain
    function automatic logic noisy(input logic kind);
        return ($urandom_range(0, 31) == 0) ? ~kind : kind;
    endfunction

    task automatic queue_random_px();
        queue_px(($urandom_range(0, 3) == 0) ? mf3_pkg::REQ_PAD : REQ_PIXEL,
                 mf3_pkg::t_pix'($urandom_range(0, 255)));
    endtask

    // one frame of random bytes plus its drain; now and then the drain is
    // cut short or overlong so that frames slip against the block's position
    task automatic queue_frame(input int unsigned w, input int unsigned h);
        int unsigned drain;
        repeat (w * h) queue_px(noisy(REQ_PIXEL), mf3_pkg::t_pix'($urandom_range(0, 255)));
        drain = w + 1;
        if ($urandom_range(0, 9) == 0) drain = drain + $urandom_range(0, 4) - 2;
        repeat (drain) queue_px(noisy(mf3_pkg::REQ_PAD), mf3_pkg::t_pix'($urandom_range(0, 255)));
    endtask

    // all items sent, all results in, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_px.size() != 0 || in_if.valid || filtered_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write then read-back, setup and access phases each
    task automatic reg_write_check(input mf3_pkg::t_reg_idx idx,
                                   input logic [mf3_pkg::CFG_W-1:0] val);
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({idx, 2'b00});
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (idx == mf3_pkg::REG_ROW_BYTES)
            cfg_row_bytes = val;
        else
            cfg_row_count = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(val)) begin
            $display("%0t: register %s read expected %0d actual %0d",
                     $time, idx.name(), val, got);
            errors++;
        end
    endtask

    // one setting: write both registers, send frames, and either stop part
    // way through a frame (tail items) or complete the frame in progress
    task automatic run_phase(input logic [mf3_pkg::CFG_W-1:0] w_raw,
                             input logic [mf3_pkg::CFG_W-1:0] h_raw,
                             input int unsigned frames, input int unsigned tail,
                             input bit calm, input bit squeeze);
        int unsigned w, h, rest;
        reg_write_check(mf3_pkg::REG_ROW_BYTES, w_raw);
        reg_write_check(mf3_pkg::REG_ROW_COUNT, h_raw);
        w = clamp_size(w_raw, mf3_pkg::MAX_ROW_BYTES_DEF);
        h = clamp_size(h_raw, mf3_pkg::ROW_COUNT_MAX);
        @(negedge i_clk);
        no_gaps = calm;
        if (squeeze) hold_req++;
        repeat (frames) queue_frame(w, h);
        repeat (tail) queue_random_px();
        wait_drained();
        if (tail == 0 && (pos_col != 0 || pos_row != 0)) begin
            rest = (h + 1) * w + 1 - (pos_row * w + pos_col);
            repeat (rest) queue_random_px();
            wait_drained();
        end
        settings_run++;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [mf3_pkg::CFG_W-1:0] w_raw, h_raw;
        int unsigned               w, h, tail;
        in_if.valid      = 1'b0;
        in_if.req_type   = REQ_PIXEL;
        in_if.pixel_byte = '0;
        out_if.ready     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 frames on the reset sizes, byte extremes, padding
        // inside the image, an image byte in the drain, back-to-back frames
        @(negedge i_clk);
        no_gaps = 1'b1;
        queue_px(REQ_PIXEL, 8'hFF);
        queue_px(REQ_PIXEL, 8'h00);
        queue_px(REQ_PIXEL, 8'h80);
        queue_px(REQ_PIXEL, 8'h01);
        queue_px(mf3_pkg::REQ_PAD, 8'hFF);
        queue_px(REQ_PIXEL, 8'hFE);
        queue_px(REQ_PIXEL, 8'h7F);
        queue_px(REQ_PIXEL, 8'hAA);
        queue_px(REQ_PIXEL, 8'h55);
        queue_px(mf3_pkg::REQ_PAD, 8'h00);
        queue_px(REQ_PIXEL, 8'hFF);
        queue_px(mf3_pkg::REQ_PAD, 8'h5A);
        queue_px(mf3_pkg::REQ_PAD, 8'hA5);
        // second frame straight after: checker pattern, five zeros outvote four ones
        for (int i = 0; i < 9; i++) queue_px(REQ_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        repeat (4) queue_px(mf3_pkg::REQ_PAD, 8'h00);
        wait_drained();

        // scripted settings: small frames, clamped lows, the widest row,
        // the tallest frame, and size changes part way through a frame
        run_phase(13'd4, 13'd4, 3, 0, 1'b0, 1'b0);
        run_phase(13'd0, 13'd0, 4, 0, 1'b0, 1'b1);
        run_phase(13'h1FFF, 13'd3, 0, 50, 1'b1, 1'b0);   // widest row, stops in row 0
        run_phase(13'd37, 13'd6, 3, 0, 1'b0, 1'b1);      // column wraps into next row
        run_phase(13'd2, 13'h1FFF, 0, 150, 1'b0, 1'b0);  // tallest frame, stops early
        run_phase(13'd5, 13'd10, 2, 0, 1'b1, 1'b0);      // position beyond drain restarts

        // random settings until enough items have gone through
        while (queued_items < ITEM_TARGET) begin
            w_raw = ($urandom_range(0, 7) == 0) ? mf3_pkg::CFG_W'($urandom_range(0, 2))
                                                : mf3_pkg::CFG_W'($urandom_range(3, 16));
            h_raw = ($urandom_range(0, 7) == 0) ? mf3_pkg::CFG_W'($urandom_range(0, 2))
                                                : mf3_pkg::CFG_W'($urandom_range(3, 9));
            w     = clamp_size(w_raw, mf3_pkg::MAX_ROW_BYTES_DEF);
            h     = clamp_size(h_raw, mf3_pkg::ROW_COUNT_MAX);
            tail  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, w * h + w) : 0;
            run_phase(w_raw, h_raw, $urandom_range(1, 3), tail,
                      $urandom_range(0, 3) == 0, settings_run % 5 == 0);
        end

        wait_drained();
        $display("%0d input transactions, %0d filtered bytes checked, %0d size settings",
                 items_taken, bytes_checked, settings_run);
        $display("rows 3 to 4096 bytes, frames 3 to 4096 rows, %0d long output hold-offs",
                 holds_done);
        if (errors == 0 && filtered_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
